### src/worst_fit_block_allocator_macros.svh
// assertion macros for the worst-fit block allocator
`ifndef WORST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define WORST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// plain property, checked at every edge outside reset
`define WFBA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("wfba assertion failed");

// same-cycle implication
`define WFBA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("wfba assertion failed");

// next-cycle implication
`define WFBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("wfba assertion failed");

`else

`define WFBA_ASSERT(lbl, clk, rstn, prop)
`define WFBA_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define WFBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### src/wfba_pkg.sv
// shared types and constants of the worst-fit block allocator
package wfba_pkg;

  localparam int SLOT_FIELD_W = 4;
  localparam int SIZE_FIELD_W = 16;
  localparam int BC_W         = 5;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [BC_W-1:0] BLOCK_COUNT_RESET = 5'd16;

  // register word index
  localparam logic REG_BLOCK_COUNT = 1'b0;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  localparam logic [1:0] STATUS_LOADED    = 2'd0;
  localparam logic [1:0] STATUS_ALLOCATED = 2'd1;
  localparam logic [1:0] STATUS_NO_FIT    = 2'd2;

  typedef struct packed {
    logic                    mode;
    logic [SLOT_FIELD_W-1:0] block_slot;
    logic [SIZE_FIELD_W-1:0] size_value;
  } in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [SLOT_FIELD_W-1:0] chosen_block;
    logic [SIZE_FIELD_W-1:0] left_free;
  } out_t;

endpackage

### src/wfba_regs.sv
// apb configuration register file: block count
module wfba_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wfba_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [wfba_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [wfba_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [wfba_pkg::BC_W-1:0]         blk_count
);
  import wfba_pkg::*;

  logic [BC_W-1:0] blk_count_r;
  logic            wr_beat;
  logic            reg_sel;

  assign pready    = 1'b1;
  assign wr_beat   = psel && penable && pwrite && pready;
  assign reg_sel   = paddr[CFG_ADDR_W-1];
  assign blk_count = blk_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_count_r <= BLOCK_COUNT_RESET;
    end else if (wr_beat && (reg_sel == REG_BLOCK_COUNT)) begin
      blk_count_r <= pwdata[BC_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BLOCK_COUNT: prdata = {{(CFG_DATA_W-BC_W){1'b0}}, blk_count_r};
      default:         prdata = '0;
    endcase
  end

endmodule

### src/wfba_cell.sv
// one table cell: holds a block's free size and updates the passing search beat
`include "worst_fit_block_allocator_macros.svh"

module wfba_cell #(
  parameter int CELL_IDX  = 0,
  parameter int SIZE_BITS = 16,
  parameter int IDX_W     = 4
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic [wfba_pkg::BC_W-1:0]                              blk_count,
  input  logic [1+IDX_W+SIZE_BITS-1:0]                           wr_in,
  input  logic [2+wfba_pkg::SIZE_FIELD_W+SIZE_BITS+IDX_W-1:0]    beat_in,
  output logic [2+wfba_pkg::SIZE_FIELD_W+SIZE_BITS+IDX_W-1:0]    beat_out
);
  import wfba_pkg::*;

  localparam int CW = (SIZE_BITS > SIZE_FIELD_W) ? SIZE_BITS : SIZE_FIELD_W;

  typedef struct packed {
    logic                    valid;
    logic                    found;
    logic [SIZE_FIELD_W-1:0] req;
    logic [SIZE_BITS-1:0]    best_val;
    logic [IDX_W-1:0]        best_idx;
  } beat_t;

  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] data;
  } wr_t;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [SIZE_BITS-1:0] free_r;
  beat_t                b_in;
  beat_t                b_nxt;
  beat_t                b_r;
  wr_t                  wr;
  logic                 active;
  logic                 fits;
  logic                 take;

  assign b_in     = beat_in;
  assign wr       = wr_in;
  assign beat_out = b_r;

  // blocks at or above the configured count sit out the search
  assign active = CELL_IDX < int'(blk_count);
  assign fits   = CW'(free_r) >= CW'(b_in.req);
  assign take   = b_in.valid && active && fits && (!b_in.found || (free_r > b_in.best_val));

  always_comb begin
    b_nxt = b_in;
    if (take) begin
      b_nxt.found    = 1'b1;
      b_nxt.best_val = free_r;
      b_nxt.best_idx = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '0;
    end else if (wr.en && (wr.idx == MY_IDX)) begin
      free_r <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.valid <= 1'b0;
    end else begin
      b_r <= b_nxt;
    end
  end

  `WFBA_ASSERT_IMPL(a_best_fits, clk, rst_n, b_r.valid && b_r.found, CW'(b_r.best_val) >= CW'(b_r.req))
  `WFBA_ASSERT_NEXT(a_take_marks, clk, rst_n, take, b_r.found && (b_r.best_idx == MY_IDX))
  `WFBA_ASSERT_NEXT(a_found_kept, clk, rst_n, b_in.valid && b_in.found, b_r.found)

endmodule

### src/worst_fit_block_allocator.sv
// worst-fit block allocator: a row of NUM_BLOCKS cells, each holding one block's free
// size, with a search beat that walks the row one cell per cycle. A load item writes
// its block directly, and its result strobe follows on the next cycle.
// A request launches a beat that visits every cell in turn, keeping the largest fitting
// size with ties to the lowest index; the reduced size is written back as the beat
// leaves the last cell. A request keeps busy high until its beat leaves the row
// of cells, and its result strobe follows. Results are shown for exactly
// one cycle on out_valid and cannot be held off by the receiver. Configuration writes
// are taken at any time but are meant for idle periods.
`include "worst_fit_block_allocator_macros.svh"

module worst_fit_block_allocator #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  wfba_pkg::in_t                     in_data,
  output logic                              out_valid,
  output wfba_pkg::out_t                    out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wfba_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [wfba_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [wfba_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import wfba_pkg::*;

  localparam int IDX_W  = $clog2(NUM_BLOCKS);
  localparam int BEAT_W = 2 + SIZE_FIELD_W + SIZE_BITS + IDX_W;
  localparam int WR_W   = 1 + IDX_W + SIZE_BITS;

  typedef struct packed {
    logic                    valid;
    logic                    found;
    logic [SIZE_FIELD_W-1:0] req;
    logic [SIZE_BITS-1:0]    best_val;
    logic [IDX_W-1:0]        best_idx;
  } beat_t;

  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] data;
  } wr_t;

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  state_t               state_r, state_nxt;
  beat_t                launch_r, launch_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_r, out_nxt;
  beat_t                chain [NUM_BLOCKS+1];
  logic [NUM_BLOCKS:0]  chain_valid;
  beat_t                tail;
  wr_t                  wr;
  logic [BC_W-1:0]      blk_count;
  logic                 accept;
  logic                 is_req;
  logic                 slot_ok;
  logic                 fin;
  logic [SIZE_BITS-1:0] load_val;
  logic [SIZE_BITS-1:0] left_val;

  wfba_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .blk_count (blk_count)
  );

  assign chain[0] = launch_r;

  for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
    logic [BEAT_W-1:0] beat_o;

    wfba_cell #(
      .CELL_IDX  (k),
      .SIZE_BITS (SIZE_BITS),
      .IDX_W     (IDX_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .blk_count (blk_count),
      .wr_in     (WR_W'(wr)),
      .beat_in   (BEAT_W'(chain[k])),
      .beat_out  (beat_o)
    );

    assign chain[k+1] = beat_o;
  end

  for (genvar k = 0; k <= NUM_BLOCKS; k++) begin : g_vld
    assign chain_valid[k] = chain[k].valid;
  end

  assign tail      = chain[NUM_BLOCKS];
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign is_req    = (in_data.mode == MODE_REQUEST);
  assign fin       = tail.valid;
  assign slot_ok   = int'(in_data.block_slot) < NUM_BLOCKS;
  assign load_val  = SIZE_BITS'(in_data.size_value);
  assign left_val  = tail.best_val - SIZE_BITS'(tail.req);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // table write port: a load at accept, or the write-back as the beat leaves the row
  always_comb begin
    wr = '0;
    if (accept && !is_req) begin
      wr.en   = slot_ok;
      wr.idx  = IDX_W'(in_data.block_slot);
      wr.data = load_val;
    end else if (fin) begin
      wr.en   = tail.found;
      wr.idx  = tail.best_idx;
      wr.data = left_val;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    launch_nxt     = launch_r;
    launch_nxt.valid = 1'b0;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_req) begin
            state_nxt           = S_SEARCH;
            launch_nxt.valid    = 1'b1;
            launch_nxt.found    = 1'b0;
            launch_nxt.req      = in_data.size_value;
            launch_nxt.best_val = '0;
            launch_nxt.best_idx = '0;
          end else begin
            out_valid_nxt        = 1'b1;
            out_nxt.status       = STATUS_LOADED;
            out_nxt.chosen_block = in_data.block_slot;
            out_nxt.left_free    = slot_ok ? SIZE_FIELD_W'(load_val) : '0;
          end
        end
      end
      S_SEARCH: begin
        if (fin) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (tail.found) begin
            out_nxt.status       = STATUS_ALLOCATED;
            out_nxt.chosen_block = SLOT_FIELD_W'(tail.best_idx);
            out_nxt.left_free    = SIZE_FIELD_W'(left_val);
          end else begin
            out_nxt.status       = STATUS_NO_FIT;
            out_nxt.chosen_block = '0;
            out_nxt.left_free    = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      launch_r.valid <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
    end
  end

  `WFBA_ASSERT_IMPL(a_strobe_src, clk, rst_n, out_valid_r, $past(accept || fin))
  `WFBA_ASSERT_IMPL(a_fin_in_search, clk, rst_n, fin, state_r == S_SEARCH)
  `WFBA_ASSERT_NEXT(a_req_busy, clk, rst_n, accept && is_req, busy && launch_r.valid)
  `WFBA_ASSERT(a_one_beat, clk, rst_n, $onehot0(chain_valid))

endmodule
